/* rtl/hcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types, codes and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int MAX_CODE  = 40;
  localparam int IDX_W     = 11;   // node slot index, 2*MAX_WORDS slots
  localparam int LEN_W     = 6;    // code length, up to MAX_CODE
  localparam int CNT_W     = 64;   // node count width

  localparam logic [CNT_W-1:0] SENTINEL = 64'd1000000000000000;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       clear;
    logic       set_stat;
    logic [1:0] stat_val;
    logic       emit_stat;
    logic       init_start;
    logic       init_step;
    logic       pick1;
    logic       pick2;
    logic       wsum;
    logic       build_done;
    logic       q_start;
    logic       q_step;
    logic       e_start;
    logic       e_step;
  } hcb_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       few;
    logic       qbad;
    logic       init_last;
    logic       merge_last;
    logic       at_root;
    logic       len_full;
    logic       epos_zero;
    logic       out_free;
  } hcb_stat_t;

endpackage

/* rtl/huffman_code_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder
// Two-queue Huffman code builder over counts loaded in descending order.
// ----------------------------------------------------------------------------
// Usage: each input word carries an op (load, build, query, clear) with a
// count or a word index. One request is handled at a time; in_stall is high
// from the cycle after acceptance until its last result word is loaded into
// the output register. Load, build, clear and any error answer with a single
// word marked last. A good query answers with one word per code bit, root
// first, the deepest marked last.
// Steps: a build first fills the internal slots with the sentinel, then each
// merge does two registered count-store reads and compares and then the sum
// write. A query walks the parent store up to the root, pushing the path
// onto the path stack, and then emits from the path stack. The stores have
// registered reads, so every step needs a fresh read after its pointer moves.
// Reset: the word total and built flag clear; the node stores are not
// cleared and are only read where written. When out_stall is high the output
// word holds and the sequencer waits before loading the next word.
// ----------------------------------------------------------------------------
module huffman_code_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [47:0] in_word_count,
  input  logic [9:0]  in_word_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_code_bit,
  output logic [9:0]  out_node,
  output logic        out_last
);

  hcb_pkg::hcb_cmd_t  cmd;
  hcb_pkg::hcb_stat_t st;

  // Sequencer: decides what the datapath does each cycle.
  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: stores, pointers and the output word register.
  hcb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_word_count (in_word_count),
    .in_word_index (in_word_index),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_code_bit  (out_code_bit),
    .out_node      (out_node),
    .out_last      (out_last)
  );

endmodule

/* rtl/hcb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for load, build, query and clear requests.
// ----------------------------------------------------------------------------
module hcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hcb_pkg::hcb_stat_t st,
  output hcb_pkg::hcb_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RESP = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_CMP1 = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_CMP2 = 4'd7;
  localparam logic [3:0] S_WRS  = 4'd8;
  localparam logic [3:0] S_QCHK = 4'd9;
  localparam logic [3:0] S_QRD  = 4'd10;
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_ELD  = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.set_stat = 1'b1;
        cmd.stat_val = hcb_pkg::ST_OK;
        state_nxt    = S_RESP;
        case (st.op)
          hcb_pkg::OP_LOAD: begin
            if (st.full) cmd.stat_val = hcb_pkg::ST_BAD;
            else cmd.load = 1'b1;
          end
          hcb_pkg::OP_BUILD: begin
            if (st.few) begin
              cmd.stat_val = hcb_pkg::ST_BAD;
            end else begin
              cmd.init_start = 1'b1;
              state_nxt      = S_INIT;
            end
          end
          hcb_pkg::OP_QUERY: begin
            if (st.qbad) begin
              cmd.stat_val = hcb_pkg::ST_BAD;
            end else begin
              cmd.q_start = 1'b1;
              state_nxt   = S_QCHK;
            end
          end
          default: cmd.clear = 1'b1;
        endcase
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_last) state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_CMP1;
      S_CMP1: begin
        cmd.pick1 = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: state_nxt = S_CMP2;
      S_CMP2: begin
        cmd.pick2 = 1'b1;
        state_nxt = S_WRS;
      end
      S_WRS: begin
        cmd.wsum = 1'b1;
        if (st.merge_last) begin
          cmd.build_done = 1'b1;
          cmd.set_stat   = 1'b1;
          cmd.stat_val   = hcb_pkg::ST_OK;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_RD1;
        end
      end
      S_QCHK: begin
        if (st.at_root) begin
          cmd.e_start = 1'b1;
          state_nxt   = S_ERD;
        end else if (st.len_full) begin
          cmd.set_stat = 1'b1;
          cmd.stat_val = hcb_pkg::ST_LONG;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_QRD: begin
        cmd.q_step = 1'b1;
        state_nxt  = S_QCHK;
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: begin
        if (st.out_free) begin
          cmd.e_step = 1'b1;
          state_nxt  = st.epos_zero ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* rtl/hcb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_datapath
// Node stores, merge pointers, code path stack and the output register.
// ----------------------------------------------------------------------------
module hcb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_op,
  input  logic [47:0]        in_word_count,
  input  logic [9:0]         in_word_index,
  input  hcb_pkg::hcb_cmd_t  cmd,
  output hcb_pkg::hcb_stat_t st,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_code_bit,
  output logic [9:0]         out_node,
  output logic               out_last
);

  logic [hcb_pkg::CNT_W-1:0] counts_mem [2*hcb_pkg::MAX_WORDS];
  logic [hcb_pkg::IDX_W-1:0] parent_mem [2*hcb_pkg::MAX_WORDS];
  logic                      branch_mem [2*hcb_pkg::MAX_WORDS];
  logic [hcb_pkg::IDX_W:0]   stack_mem  [hcb_pkg::MAX_CODE];

  logic [1:0]                op_r;
  logic [47:0]               cnt_r;
  logic [9:0]                widx_r;
  logic [hcb_pkg::IDX_W-1:0] wl_r;
  logic                      tb_r;
  logic [1:0]                stat_r;
  logic [hcb_pkg::IDX_W-1:0] idx_r;
  logic [hcb_pkg::IDX_W-1:0] leaf_r;
  logic                      leaf_ok_r;
  logic [hcb_pkg::IDX_W-1:0] inner_r;
  logic [9:0]                a_r;
  logic [hcb_pkg::CNT_W-1:0] c1_r;
  logic [hcb_pkg::CNT_W-1:0] sum_r;
  logic [hcb_pkg::CNT_W-1:0] rda_r;
  logic [hcb_pkg::CNT_W-1:0] rdb_r;
  logic [hcb_pkg::IDX_W-1:0] n_r;
  logic [hcb_pkg::LEN_W-1:0] len_r;
  logic [hcb_pkg::LEN_W-1:0] epos_r;
  logic [hcb_pkg::IDX_W-1:0] par_rd_r;
  logic                      br_rd_r;
  logic [hcb_pkg::IDX_W:0]   sd_r;
  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic                      out_code_bit_r;
  logic [9:0]                out_node_r;
  logic                      out_last_r;

  logic                      take_leaf;
  logic [hcb_pkg::IDX_W-1:0] pick_idx;
  logic [hcb_pkg::CNT_W-1:0] pick_cnt;
  logic [hcb_pkg::IDX_W-1:0] new_node;
  logic [hcb_pkg::IDX_W:0]   two_v;
  logic                      cnt_we;
  logic [hcb_pkg::IDX_W-1:0] cnt_wa;
  logic [hcb_pkg::CNT_W-1:0] cnt_wd;
  logic [hcb_pkg::IDX_W-1:0] node_rel;

  assign take_leaf = leaf_ok_r && (rda_r < rdb_r);
  assign pick_idx  = take_leaf ? leaf_r : inner_r;
  assign pick_cnt  = take_leaf ? rda_r : rdb_r;
  assign new_node  = wl_r + {1'b0, a_r};
  assign two_v     = {wl_r, 1'b0};
  assign node_rel  = sd_r[hcb_pkg::IDX_W-1:0] - wl_r;

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = wl_r;
    cnt_wd = {16'd0, cnt_r};
    if (cmd.load) begin
      cnt_we = 1'b1;
    end else if (cmd.init_step) begin
      cnt_we = 1'b1;
      cnt_wa = idx_r;
      cnt_wd = hcb_pkg::SENTINEL;
    end else if (cmd.wsum) begin
      cnt_we = 1'b1;
      cnt_wa = new_node;
      cnt_wd = sum_r;
    end
  end

  always_comb begin
    st.op         = op_r;
    st.full       = (wl_r == hcb_pkg::IDX_W'(hcb_pkg::MAX_WORDS));
    st.few        = (wl_r < hcb_pkg::IDX_W'(2));
    st.qbad       = !tb_r || ({1'b0, widx_r} >= wl_r);
    st.init_last  = ({1'b0, idx_r} == (two_v - (hcb_pkg::IDX_W+1)'(1)));
    st.merge_last = (({1'b0, a_r} + hcb_pkg::IDX_W'(1)) == (wl_r - hcb_pkg::IDX_W'(1)));
    st.at_root    = ({1'b0, n_r} == (two_v - (hcb_pkg::IDX_W+1)'(2)));
    st.len_full   = (len_r == hcb_pkg::LEN_W'(hcb_pkg::MAX_CODE));
    st.epos_zero  = (epos_r == '0);
    st.out_free   = !out_valid_r || !out_stall;
  end

  // Stores: one write port and registered reads at the current pointers.
  always_ff @(posedge clk) begin
    if (cnt_we) counts_mem[cnt_wa] <= cnt_wd;
    rda_r <= counts_mem[leaf_r];
    rdb_r <= counts_mem[inner_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.pick1 || cmd.pick2) begin
      parent_mem[pick_idx] <= new_node;
      branch_mem[pick_idx] <= cmd.pick2;
    end
    par_rd_r <= parent_mem[n_r];
    br_rd_r  <= branch_mem[n_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_step) stack_mem[len_r] <= {br_rd_r, par_rd_r};
    sd_r <= stack_mem[epos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= '0;
      tb_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        wl_r <= wl_r + hcb_pkg::IDX_W'(1);
        tb_r <= 1'b0;
      end else if (cmd.clear) begin
        wl_r <= '0;
        tb_r <= 1'b0;
      end else if (cmd.build_done) begin
        tb_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      cnt_r  <= in_word_count;
      widx_r <= in_word_index;
    end
    if (cmd.set_stat) stat_r <= cmd.stat_val;
    if (cmd.init_start) begin
      idx_r     <= wl_r;
      leaf_r    <= wl_r - hcb_pkg::IDX_W'(1);
      leaf_ok_r <= 1'b1;
      inner_r   <= wl_r;
      a_r       <= '0;
    end
    if (cmd.init_step) idx_r <= idx_r + hcb_pkg::IDX_W'(1);
    if (cmd.pick1 || cmd.pick2) begin
      if (take_leaf) begin
        leaf_r <= leaf_r - hcb_pkg::IDX_W'(1);
        if (leaf_r == '0) leaf_ok_r <= 1'b0;
      end else begin
        inner_r <= inner_r + hcb_pkg::IDX_W'(1);
      end
    end
    if (cmd.pick1) c1_r <= pick_cnt;
    if (cmd.pick2) sum_r <= c1_r + pick_cnt;
    if (cmd.wsum) a_r <= a_r + 10'd1;
    if (cmd.q_start) begin
      n_r   <= {1'b0, widx_r};
      len_r <= '0;
    end
    if (cmd.q_step) begin
      n_r   <= par_rd_r;
      len_r <= len_r + hcb_pkg::LEN_W'(1);
    end
    if (cmd.e_start) epos_r <= len_r - hcb_pkg::LEN_W'(1);
    if (cmd.e_step) epos_r <= epos_r - hcb_pkg::LEN_W'(1);
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_stat || cmd.e_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stat) begin
      out_status_r   <= stat_r;
      out_code_bit_r <= 1'b0;
      out_node_r     <= '0;
      out_last_r     <= 1'b1;
    end else if (cmd.e_step) begin
      out_status_r   <= hcb_pkg::ST_OK;
      out_code_bit_r <= sd_r[hcb_pkg::IDX_W];
      out_node_r     <= node_rel[9:0];
      out_last_r     <= (epos_r == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_code_bit = out_code_bit_r;
  assign out_node     = out_node_r;
  assign out_last     = out_last_r;

endmodule

/* sim/huffman_code_builder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_test
// Self-checking bench for the two-queue Huffman code builder.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the count, parent and branch
// stores. It works out the answer words of every accepted request and
// compares them, in order, with the words that leave the block. Stimulus is a
// short directed run, then well-formed load/build/query sequences with random
// counts, mixed with noise and deep chain-shaped trees.
// It runs in four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module huffman_code_builder_test;

  // One answer word as the block should present it.
  typedef struct {
    logic [1:0] status;
    logic       code_bit;
    logic [9:0] node;
    logic       last;
  } code_word_t;

  // The scoreboard holds a predictor of the block and the answer words that
  // are still owed.
  class huffman_scoreboard;
    logic [63:0] slot_count [2*hcb_pkg::MAX_WORDS];
    logic [10:0] slot_parent [2*hcb_pkg::MAX_WORDS];
    logic        slot_branch [2*hcb_pkg::MAX_WORDS];
    int          word_total;
    bit          tree_ready;
    code_word_t  words_due[$];
    int          fail_count;
    int          words_checked;
    int          long_codes;
    int          bad_requests;

    function new();
      word_total = 0;
      tree_ready = 0;
      fail_count = 0;
      words_checked = 0;
      long_codes = 0;
      bad_requests = 0;
    endfunction

    function void owe(logic [1:0] status, logic code_bit, logic [9:0] node,
                      logic last);
      code_word_t w;
      w.status = status;
      w.code_bit = code_bit;
      w.node = node;
      w.last = last;
      words_due.push_back(w);
      if (status == hcb_pkg::ST_BAD) bad_requests++;
      if (status == hcb_pkg::ST_LONG) long_codes++;
    endfunction

    // Takes the smaller head of the leaf queue and the internal queue; a tie
    // goes to the internal node.
    function int take_smaller(ref int leaf, ref int inner);
      int chosen;
      if (leaf >= 0 && slot_count[leaf] < slot_count[inner]) begin
        chosen = leaf;
        leaf--;
      end else begin
        chosen = inner;
        inner++;
      end
      return chosen;
    endfunction

    function void build_tree();
      int v;
      int leaf;
      int inner;
      int m1;
      int m2;
      v = word_total;
      leaf = v - 1;
      inner = v;
      for (int i = v; i < 2 * v; i++) slot_count[i] = hcb_pkg::SENTINEL;
      for (int a = 0; a + 1 < v; a++) begin
        m1 = take_smaller(leaf, inner);
        m2 = take_smaller(leaf, inner);
        if (m1 >= 2 * hcb_pkg::MAX_WORDS || m2 >= 2 * hcb_pkg::MAX_WORDS) break;
        slot_count[v + a] = slot_count[m1] + slot_count[m2];
        slot_parent[m1] = 11'(v + a);
        slot_parent[m2] = 11'(v + a);
        slot_branch[m1] = 1'b0;
        slot_branch[m2] = 1'b1;
      end
      tree_ready = 1;
    endfunction

    // Walks from the leaf to the root, then owes the code root first.
    function void answer_query(int w);
      int n;
      int root;
      int depth;
      logic [10:0] up_path [hcb_pkg::MAX_CODE];
      logic        bit_path [hcb_pkg::MAX_CODE];
      logic [10:0] rel;
      if (!tree_ready || w >= word_total) begin
        owe(hcb_pkg::ST_BAD, 1'b0, 10'd0, 1'b1);
        return;
      end
      root = 2 * word_total - 2;
      n = w;
      depth = 0;
      while (n != root) begin
        if (depth >= hcb_pkg::MAX_CODE) begin
          owe(hcb_pkg::ST_LONG, 1'b0, 10'd0, 1'b1);
          return;
        end
        if (n >= 2 * hcb_pkg::MAX_WORDS) begin
          owe(hcb_pkg::ST_BAD, 1'b0, 10'd0, 1'b1);
          return;
        end
        up_path[depth] = slot_parent[n];
        bit_path[depth] = slot_branch[n];
        n = int'(slot_parent[n]);
        depth++;
      end
      for (int d = 0; d < depth; d++) begin
        rel = up_path[depth - 1 - d] - 11'(word_total);
        owe(hcb_pkg::ST_OK, bit_path[depth - 1 - d], rel[9:0], d + 1 == depth);
      end
    endfunction

    function void note_request(logic [1:0] op, logic [47:0] cnt, logic [9:0] idx);
      case (op)
        hcb_pkg::OP_LOAD: begin
          if (word_total >= hcb_pkg::MAX_WORDS) begin
            owe(hcb_pkg::ST_BAD, 1'b0, 10'd0, 1'b1);
          end else begin
            slot_count[word_total] = {16'd0, cnt};
            word_total++;
            tree_ready = 0;
            owe(hcb_pkg::ST_OK, 1'b0, 10'd0, 1'b1);
          end
        end
        hcb_pkg::OP_BUILD: begin
          if (word_total < 2) begin
            owe(hcb_pkg::ST_BAD, 1'b0, 10'd0, 1'b1);
          end else begin
            build_tree();
            owe(hcb_pkg::ST_OK, 1'b0, 10'd0, 1'b1);
          end
        end
        hcb_pkg::OP_CLEAR: begin
          word_total = 0;
          tree_ready = 0;
          owe(hcb_pkg::ST_OK, 1'b0, 10'd0, 1'b1);
        end
        default: answer_query(int'(idx));
      endcase
    endfunction

    function void check_word(logic [1:0] status, logic code_bit, logic [9:0] node,
                             logic last);
      code_word_t e;
      words_checked++;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word status=%0d bit=%0d node=%0d last=%0d",
                 $time, status, code_bit, node, last);
        fail_count++;
        return;
      end
      e = words_due.pop_front();
      if (status !== e.status || code_bit !== e.code_bit || node !== e.node ||
          last !== e.last) begin
        $display("%0t: mismatch expected status=%0d bit=%0d node=%0d last=%0d",
                 $time, e.status, e.code_bit, e.node, e.last);
        $display("%0t:          actual   status=%0d bit=%0d node=%0d last=%0d",
                 $time, status, code_bit, node, last);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [47:0] in_word_count;
  logic [9:0]  in_word_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_code_bit;
  logic [9:0]  out_node;
  logic        out_last;

  huffman_code_builder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_word_count (in_word_count),
    .in_word_index (in_word_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_code_bit  (out_code_bit),
    .out_node      (out_node),
    .out_last      (out_last)
  );

  huffman_scoreboard sb = new();

  // Percent of cycles in which the sender idles and the receiver stalls.
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int quiet_cycles = 0;

  // A large build moves no word on either channel while it runs, so the
  // watchdog limit sits well above a full 1024-word build.
  localparam int QUIET_LIMIT = 60000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; the stall changes only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both channels are sampled at the rising edge. The scoreboard learns of
  // each accepted request and checks each accepted answer word, and the
  // watchdog counts the cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_op, in_word_count, in_word_index);
      if (out_valid && !out_stall) sb.check_word(out_status, out_code_bit, out_node, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("huffman_code_builder verification failed");
        $finish;
      end
    end
  end

  // Presents one request word. Idle cycles come first, so a gap can fall
  // anywhere in the work of the block; the payload then holds until taken.
  task automatic send_request(logic [1:0] op, logic [47:0] cnt, logic [9:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_word_count <= cnt;
    in_word_index <= idx;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    requests_sent++;
  endtask

  // Lowers valid and waits until every owed word has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_count();
    return 48'({$urandom, $urandom} >> $urandom_range(47));
  endfunction

  // Clear, load n counts that fall (or, now and then, do not), build, and
  // ask for a few codes. Most indices fall inside the loaded range.
  task automatic sorted_sequence(int n, bit unsorted);
    logic [47:0] c;
    c = 48'({$urandom, $urandom});
    c = c >> $urandom_range(30);
    send_request(hcb_pkg::OP_CLEAR, rand_count(), 10'($urandom));
    for (int i = 0; i < n; i++) begin
      send_request(hcb_pkg::OP_LOAD, unsorted ? rand_count() : c, 10'($urandom));
      c = 48'((64'(c) * $urandom_range(255)) >> 8);
      if ($urandom_range(9) == 0) c = c + 48'($urandom_range(3));
    end
    send_request(hcb_pkg::OP_BUILD, rand_count(), 10'($urandom));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(7) == 0) begin
        send_request(hcb_pkg::OP_QUERY, rand_count(), 10'($urandom));
      end else begin
        send_request(hcb_pkg::OP_QUERY, rand_count(), 10'($urandom_range(n - 1)));
      end
    end
  endtask

  // Halving counts give a chain-shaped tree whose deepest codes pass the
  // code length limit.
  task automatic chain_sequence();
    send_request(hcb_pkg::OP_CLEAR, 48'd0, 10'd0);
    for (int i = 0; i < 46; i++) send_request(hcb_pkg::OP_LOAD, 48'd1 << (45 - i), 10'd0);
    send_request(hcb_pkg::OP_LOAD, 48'd1, 10'd0);
    send_request(hcb_pkg::OP_BUILD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd46);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'($urandom_range(30, 45)));
  endtask

  initial begin
    int phase_start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = hcb_pkg::OP_LOAD;
    in_word_count = 48'd0;
    in_word_index = 10'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: queries and builds before any word exists, a one-word build,
    // the extreme counts (also out of order), indices out of range, a load
    // after a build and a clear.
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_BUILD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_LOAD, 48'hFFFF_FFFF_FFFF, 10'h3FF);
    send_request(hcb_pkg::OP_BUILD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_LOAD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_BUILD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd1);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd2);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'h3FF);
    send_request(hcb_pkg::OP_LOAD, 48'd5, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd2);
    send_request(hcb_pkg::OP_BUILD, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd2);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd1);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_CLEAR, 48'd0, 10'd0);
    send_request(hcb_pkg::OP_QUERY, 48'd0, 10'd0);
    drain();

    // Four phases of idling and stalling; the sender drains between them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      phase_start = requests_sent;
      chain_sequence();
      while (requests_sent - phase_start < 110) begin
        case ($urandom_range(19))
          0, 1: send_request(2'($urandom), rand_count(), 10'($urandom));
          2: sorted_sequence($urandom_range(2, 60), 1'b0);
          3: sorted_sequence($urandom_range(2, 16), 1'b1);
          default: sorted_sequence($urandom_range(2, 20), 1'b0);
        endcase
      end
      drain();
    end

    $display("Sent %0d requests and checked %0d answer words, with %0d refused requests",
             requests_sent, sb.words_checked, sb.bad_requests);
    $display("and %0d over-long codes, across four idle and stall mixes.", sb.long_codes);
    if (sb.fail_count == 0 && sb.words_due.size() == 0) begin
      $display("huffman_code_builder verification clean");
    end else begin
      $display("huffman_code_builder verification failed");
    end
    $finish;
  end

endmodule
